// ===== src/cprp_pkg.sv =====
// Package for the corner-point rectangle placer: request and result types,
// register indexes, status codes and the controller/datapath command types.
// No dependencies.
package cprp_pkg;

  localparam int COORD_BITS    = 16;
  localparam int DEF_MAX_RECTS = 64;
  localparam int COEF_BITS     = 17;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [COORD_BITS-1:0] RST_CANVAS_W = 16'd1920;
  localparam logic [COORD_BITS-1:0] RST_CANVAS_H = 16'd1080;
  localparam logic [COEF_BITS-1:0]  RST_COEF     = 17'd65536;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_W = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_H = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_FAILED  = 2'd1;
  localparam logic [1:0] ST_SKIPPED = 2'd2;

  typedef struct packed {
    logic                  first_item;
    logic                  pos_fixed;
    logic [COORD_BITS-1:0] given_x;
    logic [COORD_BITS-1:0] given_y;
    logic [COORD_BITS-1:0] item_width;
    logic [COORD_BITS-1:0] item_height;
    logic [COORD_BITS-1:0] min_width;
    logic [COORD_BITS-1:0] min_height;
  } item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  rotated;
    logic [COORD_BITS-1:0] place_x;
    logic [COORD_BITS-1:0] place_y;
    logic [COORD_BITS-1:0] place_width;
    logic [COORD_BITS-1:0] place_height;
  } result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } rect_t;

  // point memory write data select
  typedef enum logic [2:0] {
    PW_ZERO,
    PW_RDATA,
    PW_FRONT,
    PW_BACK,
    PW_KEY
  } pt_wsel_t;

  typedef struct packed {
    logic       load_item;
    logic       pt_we;
    pt_wsel_t   pt_wsel;
    logic       rect_we;
    logic       cand_given;
    logic       cand_pt;
    logic       dim_load;
    logic       dim_swap;
    logic       mul;
    logic       scale;
    logic       key_load;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_rot;
  } cmd_t;

  typedef struct packed {
    logic bounds_ok;
    logic hit;
    logic y_greater;
  } sts_t;

endpackage

// ===== src/corner_point_rectangle_placer_top.sv =====
// Top level of the corner-point rectangle placer.
// Instantiates cprp_ctrl and cprp_dp; depends on cprp_pkg.
//
// Usage:
//  - Request channel (item_valid/item_stall/item): one request per rectangle.
//    A request is taken when item_valid is high and item_stall is low; the
//    block stalls while it works on a request.
//  - Result channel (result_valid/result_stall/result): one result per
//    request, held in an output register until taken. The next request is
//    accepted while a result still waits; a finished result waits in the
//    final state only if the previous one is still not taken.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//    index 0 canvas width, 1 canvas height, 2 scale coefficient (Q1.16).
//    Write only while idle.
//  - Work per request: setup, then a fit check of each candidate point
//    tried against the R placed rectangles (one store read per cycle), up
//    to two passes over P points, plus the point list insertion sort (one
//    memory access per cycle) and list shifting and point removal after a
//    placement.
//  - Reset (rst, synchronous): empty store, point list holds only (0,0),
//    config back to 1920 x 1080 at scale 1.0, no result pending.
module corner_point_rectangle_placer_top #(
  parameter int MAX_RECTS = cprp_pkg::DEF_MAX_RECTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  cprp_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output cprp_pkg::result_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cprp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [cprp_pkg::COEF_BITS-1:0]    cfg_data
);
  import cprp_pkg::*;

  localparam int PA_W = $clog2(2 * MAX_RECTS + 1);
  localparam int RA_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

  cmd_t            cmd;
  sts_t            sts;
  logic [PA_W-1:0] pt_raddr, pt_waddr;
  logic [RA_W-1:0] rect_raddr, rect_waddr;

  // config registers take a write every cycle
  assign cfg_ready = 1'b1;

  cprp_ctrl #(
    .MAX_RECTS(MAX_RECTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_first   (item.first_item),
    .item_fixed   (item.pos_fixed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd),
    .pt_raddr     (pt_raddr),
    .pt_waddr     (pt_waddr),
    .rect_raddr   (rect_raddr),
    .rect_waddr   (rect_waddr)
  );

  cprp_dp #(
    .MAX_RECTS(MAX_RECTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item),
    .cmd        (cmd),
    .pt_raddr   (pt_raddr),
    .pt_waddr   (pt_waddr),
    .rect_raddr (rect_raddr),
    .rect_waddr (rect_waddr),
    .sts        (sts),
    .result     (result)
  );

endmodule

// ===== src/cprp_dp.sv =====
// Datapath of the rectangle placer: config registers, point and rectangle
// memories, scaling multipliers, fit compares and the result register.
// Depends on cprp_pkg.
module cprp_dp #(
  parameter int MAX_RECTS = cprp_pkg::DEF_MAX_RECTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [cprp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [cprp_pkg::COEF_BITS-1:0]      cfg_data,
  input  cprp_pkg::item_t                     item,
  input  cprp_pkg::cmd_t                      cmd,
  input  logic [$clog2(2*MAX_RECTS+1)-1:0]    pt_raddr,
  input  logic [$clog2(2*MAX_RECTS+1)-1:0]    pt_waddr,
  input  logic [((MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1)-1:0] rect_raddr,
  input  logic [((MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1)-1:0] rect_waddr,
  output cprp_pkg::sts_t                      sts,
  output cprp_pkg::result_t                   result
);
  import cprp_pkg::*;

  localparam int PT_DEPTH = 2 * MAX_RECTS + 1;
  localparam int CW       = COORD_BITS;
  localparam int PW       = CW + COEF_BITS;

  logic [CW-1:0]        canvas_w, canvas_h;
  logic [COEF_BITS-1:0] coef;
  logic [CW-1:0]        w, h, mw, mh, gx, gy;
  logic [PW-1:0]        prod_w, prod_h;
  logic [CW-1:0]        sw, sh;
  logic [CW-1:0]        tw, th;
  point_t               cand, key, pdata, pt_wdata;
  rect_t                rdata;
  point_t               pmem [PT_DEPTH];
  rect_t                rmem [MAX_RECTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_w <= RST_CANVAS_W;
      canvas_h <= RST_CANVAS_H;
      coef     <= RST_COEF;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CANVAS_W: canvas_w <= cfg_data[CW-1:0];
        REG_CANVAS_H: canvas_h <= cfg_data[CW-1:0];
        REG_SCALE:    coef     <= cfg_data;
        default: ;
      endcase
    end
  end

  // truncate, saturate at full scale
  assign sw = prod_w[PW-1] ? '1 : prod_w[PW-2:16];
  assign sh = prod_h[PW-1] ? '1 : prod_h[PW-2:16];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      w  <= item.item_width;
      h  <= item.item_height;
      mw <= item.min_width;
      mh <= item.min_height;
      gx <= item.given_x;
      gy <= item.given_y;
    end else if (cmd.scale) begin
      if (sw < mw || sh < mh) begin
        w <= mw;
        h <= mh;
      end else begin
        w <= sw;
        h <= sh;
      end
    end
    if (cmd.mul) begin
      prod_w <= PW'(w) * PW'(coef);
      prod_h <= PW'(h) * PW'(coef);
    end
    if (cmd.dim_load) begin
      tw <= w;
      th <= h;
    end else if (cmd.dim_swap) begin
      tw <= h;
      th <= w;
    end
    if (cmd.cand_given) begin
      cand.x <= gx;
      cand.y <= gy;
    end else if (cmd.cand_pt) begin
      cand <= pdata;
    end
    if (cmd.key_load) begin
      key <= pdata;
    end
  end

  always_comb begin
    case (cmd.pt_wsel)
      PW_ZERO:  pt_wdata = '0;
      PW_RDATA: pt_wdata = pdata;
      PW_FRONT: pt_wdata = '{x: cand.x + tw, y: cand.y};
      PW_BACK:  pt_wdata = '{x: cand.x, y: cand.y + th};
      PW_KEY:   pt_wdata = key;
      default:  pt_wdata = '0;
    endcase
  end

  // reset leaves the list holding only the origin
  always_ff @(posedge clk) begin
    if (rst) begin
      pmem[0] <= '0;
    end else if (cmd.pt_we) begin
      pmem[pt_waddr] <= pt_wdata;
    end
    pdata <= pmem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rect_we) begin
      rmem[rect_waddr] <= '{x: cand.x, y: cand.y, w: tw, h: th};
    end
    rdata <= rmem[rect_raddr];
  end

  always_comb begin
    sts.bounds_ok = ({1'b0, cand.x} + {1'b0, tw} <= {1'b0, canvas_w}) &&
                    ({1'b0, cand.y} + {1'b0, th} <= {1'b0, canvas_h});
    sts.hit = (tw != '0) && (th != '0) && (rdata.w != '0) && (rdata.h != '0) &&
              ({1'b0, cand.x} < {1'b0, rdata.x} + {1'b0, rdata.w}) &&
              ({1'b0, rdata.x} < {1'b0, cand.x} + {1'b0, tw}) &&
              ({1'b0, cand.y} < {1'b0, rdata.y} + {1'b0, rdata.h}) &&
              ({1'b0, rdata.y} < {1'b0, cand.y} + {1'b0, th});
    sts.y_greater = pdata.y > key.y;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_status)
        ST_PLACED: result <= '{status: ST_PLACED, rotated: cmd.res_rot,
                               place_x: cand.x, place_y: cand.y,
                               place_width: tw, place_height: th};
        ST_FAILED: result <= '{status: ST_FAILED, rotated: 1'b0,
                               place_x: '0, place_y: '0,
                               place_width: w, place_height: h};
        default:   result <= '{status: ST_SKIPPED, default: '0};
      endcase
    end
  end

endmodule

// ===== src/cprp_ctrl.sv =====
// Controller of the rectangle placer: sequencing state machine, list and
// store counts, run flags and the result handshake. Depends on cprp_pkg.
module cprp_ctrl #(
  parameter int MAX_RECTS = cprp_pkg::DEF_MAX_RECTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                item_first,
  input  logic                                item_fixed,
  output logic                                result_valid,
  input  logic                                result_stall,
  input  cprp_pkg::sts_t                      sts,
  output cprp_pkg::cmd_t                      cmd,
  output logic [$clog2(2*MAX_RECTS+1)-1:0]    pt_raddr,
  output logic [$clog2(2*MAX_RECTS+1)-1:0]    pt_waddr,
  output logic [((MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1)-1:0] rect_raddr,
  output logic [((MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1)-1:0] rect_waddr
);
  import cprp_pkg::*;

  localparam int PT_DEPTH = 2 * MAX_RECTS + 1;
  localparam int PA_W     = $clog2(PT_DEPTH);
  localparam int PC_W     = $clog2(PT_DEPTH + 1);
  localparam int RA_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int RC_W     = $clog2(MAX_RECTS + 1);
  localparam logic [RC_W-1:0] RC_FULL = RC_W'(MAX_RECTS);

  typedef enum logic [20:0] {
    S_IDLE   = 21'b1 << 0,
    S_DECIDE = 21'b1 << 1,
    S_MUL    = 21'b1 << 2,
    S_SCALE  = 21'b1 << 3,
    S_CHECK  = 21'b1 << 4,
    S_SO_KRD = 21'b1 << 5,
    S_SO_KLD = 21'b1 << 6,
    S_SO_RD  = 21'b1 << 7,
    S_SO_CMP = 21'b1 << 8,
    S_SO_PUT = 21'b1 << 9,
    S_SEARCH = 21'b1 << 10,
    S_CAND   = 21'b1 << 11,
    S_BND    = 21'b1 << 12,
    S_FIT    = 21'b1 << 13,
    S_SHU_RD = 21'b1 << 14,
    S_SHU_WR = 21'b1 << 15,
    S_INS_F  = 21'b1 << 16,
    S_INS_B  = 21'b1 << 17,
    S_DR_RD  = 21'b1 << 18,
    S_DR_WR  = 21'b1 << 19,
    S_FINISH = 21'b1 << 20
  } state_t;

  state_t          state, state_next;
  logic [PC_W-1:0] point_count, point_count_next;
  logic [RC_W-1:0] rect_count, rect_count_next;
  logic [PC_W-1:0] k, k_next, si, si_next, j, j_next;
  logic [RC_W-1:0] fi, fi_next;
  logic            rpend, rpend_next;
  logic            pass, pass_next;
  logic            mode_fixed, mode_fixed_next;
  logic            needs_sort, needs_sort_next;
  logic            in_prefix, in_prefix_next;
  logic            run_failed, run_failed_next;
  logic            fixed_q, fixed_q_next;
  logic [1:0]      res_status, res_status_next;
  logic            res_rot, res_rot_next;
  logic            out_valid, out_valid_next;
  logic            fit_fail, fit_ok;

  assign item_stall   = (state != S_IDLE);
  assign result_valid = out_valid;
  assign rect_raddr   = fi[RA_W-1:0];
  assign rect_waddr   = rect_count[RA_W-1:0];

  always_comb begin
    state_next       = state;
    point_count_next = point_count;
    rect_count_next  = rect_count;
    k_next           = k;
    si_next          = si;
    j_next           = j;
    fi_next          = fi;
    rpend_next       = rpend;
    pass_next        = pass;
    mode_fixed_next  = mode_fixed;
    needs_sort_next  = needs_sort;
    in_prefix_next   = in_prefix;
    run_failed_next  = run_failed;
    fixed_q_next     = fixed_q;
    res_status_next  = res_status;
    res_rot_next     = res_rot;
    out_valid_next   = out_valid;
    cmd              = '0;
    cmd.pt_wsel      = PW_ZERO;
    cmd.res_status   = res_status;
    cmd.res_rot      = res_rot;
    pt_raddr         = '0;
    pt_waddr         = '0;
    fit_fail         = 1'b0;
    fit_ok           = 1'b0;

    if (out_valid && !result_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          fixed_q_next  = item_fixed;
          if (item_first) begin
            rect_count_next  = '0;
            point_count_next = PC_W'(1);
            needs_sort_next  = 1'b0;
            in_prefix_next   = 1'b1;
            run_failed_next  = 1'b0;
            cmd.pt_we        = 1'b1;
            cmd.pt_wsel      = PW_ZERO;
          end
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        pass_next    = 1'b0;
        res_rot_next = 1'b0;
        if (run_failed) begin
          res_status_next = ST_SKIPPED;
          state_next      = S_FINISH;
        end else if (in_prefix && fixed_q) begin
          mode_fixed_next = 1'b1;
          if (rect_count == RC_FULL) begin
            res_status_next = ST_FAILED;
            state_next      = S_FINISH;
          end else begin
            cmd.cand_given = 1'b1;
            cmd.dim_load   = 1'b1;
            state_next     = S_BND;
          end
        end else begin
          in_prefix_next  = 1'b0;
          mode_fixed_next = 1'b0;
          state_next      = fixed_q ? S_CHECK : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.dim_load = 1'b1;
        k_next       = '0;
        pass_next    = 1'b0;
        if (rect_count == RC_FULL) begin
          res_status_next = ST_FAILED;
          state_next      = S_FINISH;
        end else if (needs_sort && point_count > PC_W'(1)) begin
          si_next    = PC_W'(1);
          state_next = S_SO_KRD;
        end else begin
          needs_sort_next = 1'b0;
          state_next      = S_SEARCH;
        end
      end
      // stable insertion sort of the point list by y
      S_SO_KRD: begin
        pt_raddr   = si[PA_W-1:0];
        state_next = S_SO_KLD;
      end
      S_SO_KLD: begin
        cmd.key_load = 1'b1;
        j_next       = si;
        state_next   = S_SO_RD;
      end
      S_SO_RD: begin
        if (j == '0) begin
          state_next = S_SO_PUT;
        end else begin
          pt_raddr   = PA_W'(j - PC_W'(1));
          state_next = S_SO_CMP;
        end
      end
      S_SO_CMP: begin
        if (sts.y_greater) begin
          cmd.pt_we   = 1'b1;
          cmd.pt_wsel = PW_RDATA;
          pt_waddr    = j[PA_W-1:0];
          j_next      = j - PC_W'(1);
          state_next  = S_SO_RD;
        end else begin
          state_next = S_SO_PUT;
        end
      end
      S_SO_PUT: begin
        cmd.pt_we   = 1'b1;
        cmd.pt_wsel = PW_KEY;
        pt_waddr    = j[PA_W-1:0];
        if (si + PC_W'(1) == point_count) begin
          needs_sort_next = 1'b0;
          state_next      = S_SEARCH;
        end else begin
          si_next    = si + PC_W'(1);
          state_next = S_SO_KRD;
        end
      end
      S_SEARCH: begin
        pt_raddr   = k[PA_W-1:0];
        state_next = S_CAND;
      end
      S_CAND: begin
        cmd.cand_pt = 1'b1;
        state_next  = S_BND;
      end
      S_BND: begin
        if (!sts.bounds_ok) begin
          fit_fail = 1'b1;
        end else begin
          fi_next    = '0;
          rpend_next = 1'b0;
          state_next = S_FIT;
        end
      end
      // one stored rectangle read per cycle, compared the cycle after
      S_FIT: begin
        if (rpend && sts.hit) begin
          fit_fail = 1'b1;
        end else if (fi == rect_count) begin
          fit_ok = 1'b1;
        end else begin
          fi_next    = fi + RC_W'(1);
          rpend_next = 1'b1;
        end
      end
      S_SHU_RD: begin
        pt_raddr   = j[PA_W-1:0];
        state_next = S_SHU_WR;
      end
      S_SHU_WR: begin
        cmd.pt_we   = 1'b1;
        cmd.pt_wsel = PW_RDATA;
        pt_waddr    = PA_W'(j + PC_W'(1));
        if (j == '0) begin
          state_next = S_INS_F;
        end else begin
          j_next     = j - PC_W'(1);
          state_next = S_SHU_RD;
        end
      end
      S_INS_F: begin
        cmd.pt_we   = 1'b1;
        cmd.pt_wsel = PW_FRONT;
        state_next  = S_INS_B;
      end
      S_INS_B: begin
        cmd.pt_we        = 1'b1;
        cmd.pt_wsel      = PW_BACK;
        pt_waddr         = PA_W'(point_count + PC_W'(1));
        point_count_next = point_count + PC_W'(2);
        needs_sort_next  = 1'b1;
        if (mode_fixed) begin
          res_status_next = ST_PLACED;
          state_next      = S_FINISH;
        end else begin
          // used point moved one place down by the front insert
          j_next     = k + PC_W'(1);
          state_next = S_DR_RD;
        end
      end
      S_DR_RD: begin
        pt_raddr   = PA_W'(j + PC_W'(1));
        state_next = S_DR_WR;
      end
      S_DR_WR: begin
        cmd.pt_we   = 1'b1;
        cmd.pt_wsel = PW_RDATA;
        pt_waddr    = j[PA_W-1:0];
        if (j + PC_W'(2) == point_count) begin
          point_count_next = point_count - PC_W'(1);
          res_status_next  = ST_PLACED;
          state_next       = S_FINISH;
        end else begin
          j_next     = j + PC_W'(1);
          state_next = S_DR_RD;
        end
      end
      S_FINISH: begin
        if (!out_valid || !result_stall) begin
          cmd.res_load   = 1'b1;
          out_valid_next = 1'b1;
          if (res_status == ST_FAILED) begin
            run_failed_next = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fit_fail) begin
      if (mode_fixed) begin
        res_status_next = ST_FAILED;
        res_rot_next    = 1'b0;
        state_next      = S_FINISH;
      end else if (k + PC_W'(1) == point_count) begin
        if (!pass) begin
          pass_next    = 1'b1;
          cmd.dim_swap = 1'b1;
          k_next       = '0;
          state_next   = S_SEARCH;
        end else begin
          res_status_next = ST_FAILED;
          res_rot_next    = 1'b0;
          state_next      = S_FINISH;
        end
      end else begin
        k_next     = k + PC_W'(1);
        state_next = S_SEARCH;
      end
    end

    if (fit_ok) begin
      cmd.rect_we     = 1'b1;
      rect_count_next = rect_count + RC_W'(1);
      res_rot_next    = pass;
      j_next          = point_count - PC_W'(1);
      state_next      = S_SHU_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= PC_W'(1);
      rect_count  <= '0;
      needs_sort  <= 1'b0;
      in_prefix   <= 1'b1;
      run_failed  <= 1'b0;
      out_valid   <= 1'b0;
      k           <= '0;
      si          <= '0;
      j           <= '0;
      fi          <= '0;
      rpend       <= 1'b0;
      pass        <= 1'b0;
      mode_fixed  <= 1'b0;
      fixed_q     <= 1'b0;
      res_status  <= ST_PLACED;
      res_rot     <= 1'b0;
    end else begin
      state       <= state_next;
      point_count <= point_count_next;
      rect_count  <= rect_count_next;
      needs_sort  <= needs_sort_next;
      in_prefix   <= in_prefix_next;
      run_failed  <= run_failed_next;
      out_valid   <= out_valid_next;
      k           <= k_next;
      si          <= si_next;
      j           <= j_next;
      fi          <= fi_next;
      rpend       <= rpend_next;
      pass        <= pass_next;
      mode_fixed  <= mode_fixed_next;
      fixed_q     <= fixed_q_next;
      res_status  <= res_status_next;
      res_rot     <= res_rot_next;
    end
  end

  // point list never empty and never past its depth
  assert property (@(posedge clk) disable iff (rst)
    (point_count != '0) && (point_count <= PC_W'(PT_DEPTH)))
    else $error("point count out of range");

  assert property (@(posedge clk) disable iff (rst) rect_count <= RC_FULL)
    else $error("rect count past store size");

  // fit scan never runs past the filled part of the store
  assert property (@(posedge clk) disable iff (rst) (state == S_FIT) |-> (fi <= rect_count))
    else $error("fit scan past rect count");

  // a failed run only skips, never searches
  assert property (@(posedge clk) disable iff (rst) (state == S_SEARCH) |-> !run_failed)
    else $error("search after run failure");

  // a new placement always follows a successful fit
  assert property (@(posedge clk) disable iff (rst)
    (rect_count != $past(rect_count)) && !$past(cmd.load_item) |->
      $past(state) == S_FIT)
    else $error("store grew outside fit check");

endmodule
